[rtl/assert_macros.svh]
// ---------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion shorthands clocked on clk and disabled while arst_n is low.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold in the same cycle as its antecedent.
`define ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Property whose consequent must hold in the cycle after its antecedent.
`define ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[rtl/att_pkg.sv]
// ---------------------------------------------------------------------------
// att_pkg
// Shared widths, codes and defaults of the address tracking table.
// ---------------------------------------------------------------------------
`default_nettype none

package att_pkg;

	localparam int ENTRIES_DEFAULT = 32;
	localparam int ADDR_W          = 64;
	localparam int SLOT_W          = 5;
	localparam int STATUS_W        = 2;

	typedef enum logic {
		OP_RECORD = 1'b0,
		OP_CHECK  = 1'b1
	} att_op_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_RECORDED  = 2'd0,
		ST_FULL      = 2'd1,
		ST_FOUND     = 2'd2,
		ST_NOT_FOUND = 2'd3
	} att_status_t;

endpackage

`default_nettype wire

[rtl/att_if.sv]
// ---------------------------------------------------------------------------
// att_if
// Request and response channel interfaces with valid/ready handshake.
// ---------------------------------------------------------------------------
`default_nettype none

interface att_req_if import att_pkg::*; ();
	logic              valid;
	logic              ready;
	logic              op;
	logic [ADDR_W-1:0] address;

	modport source (output valid, output op, output address, input ready);
	modport sink   (input valid, input op, input address, output ready);
endinterface

interface att_rsp_if import att_pkg::*; ();
	logic                valid;
	logic                ready;
	logic [STATUS_W-1:0] status;
	logic [SLOT_W-1:0]   slot;

	modport source (output valid, output status, output slot, input ready);
	modport sink   (input valid, input status, input slot, output ready);
endinterface

`default_nettype wire

[rtl/att_store.sv]
// ---------------------------------------------------------------------------
// att_store
// Address store: one write port, one read port with registered read data.
// ---------------------------------------------------------------------------
`default_nettype none

module att_store import att_pkg::*; #(
	parameter int ENTRIES = ENTRIES_DEFAULT,
	localparam int IW = $clog2(ENTRIES)
) (
	input  wire logic              clk,
	input  wire logic              wr_en,
	input  wire logic [IW-1:0]     wr_idx,
	input  wire logic [ADDR_W-1:0] wr_data,
	input  wire logic              rd_en,
	input  wire logic [IW-1:0]     rd_idx,
	output logic      [ADDR_W-1:0] rd_data
);

	logic [ADDR_W-1:0] mem [ENTRIES];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_idx] <= wr_data;
		end
	end

	// hold read data when no read is issued
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_idx];
		end
	end

endmodule

`default_nettype wire

[rtl/address_tracking_table.sv]
// ---------------------------------------------------------------------------
// address_tracking_table
// Fixed table of tracked addresses with a used-slot bitmap.
// ---------------------------------------------------------------------------
// One request is worked on at a time. A request is accepted in idle, then
// slots are visited from 0 upward through the address store read port,
// pipelined so one slot is compared each cycle until the scan finishes;
// the registered read data reaches the compare stage with its slot index.
// A scan ends at the first hit or after the last slot is compared.
// The result sits in an output register, so the next request is taken
// while an earlier result still waits for its transfer; a finished scan
// holds only if that register is still occupied. Record fills the lowest
// free slot (status recorded) or drops the request (status full, slot 0).
// Check-and-remove frees the lowest used slot holding the address (status
// found) or reports not found with slot 0. The used bitmap is cleared by
// reset; the address store is not, and is only compared where used.
// ---------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module address_tracking_table import att_pkg::*; #(
	parameter int ENTRIES = ENTRIES_DEFAULT,
	localparam int IW = $clog2(ENTRIES)
) (
	input  wire logic  clk,
	input  wire logic  arst_n,
	att_req_if.sink    req,
	att_rsp_if.source  rsp
);

	localparam logic [IW-1:0] LAST = IW'(ENTRIES - 1);

	typedef enum logic {
		S_IDLE,
		S_SCAN
	} state_t;

	state_t            state_q;
	att_op_t           op_q;
	logic [ADDR_W-1:0] addr_q;
	logic [IW-1:0]     issue_idx_q;
	logic              issue_on_q;
	logic              valid_s1;
	logic [IW-1:0]     idx_s1;
	logic [ENTRIES-1:0] used_q;

	logic                out_valid_q;
	logic [STATUS_W-1:0] out_status_q;
	logic [SLOT_W-1:0]   out_slot_q;

	logic [ADDR_W-1:0] rd_data;
	logic              used_bit;
	logic              hit;
	logic              finish;
	logic              out_free;
	logic              stall;
	logic              rd_en;
	logic              wr_en;
	logic              accept;

	assign accept    = req.valid && req.ready;
	assign req.ready = (state_q == S_IDLE);

	assign rsp.valid  = out_valid_q;
	assign rsp.status = out_status_q;
	assign rsp.slot   = out_slot_q;

	// Compare stage: a record wants a free slot, a lookup a used slot
	// whose stored address matches.
	assign used_bit = used_q[idx_s1];
	always_comb begin
		case (op_q)
			OP_RECORD: hit = !used_bit;
			OP_CHECK:  hit = used_bit && (rd_data == addr_q);
			default:   hit = 1'b0;
		endcase
	end

	assign finish   = valid_s1 && (hit || (idx_s1 == LAST));
	assign out_free = !out_valid_q || rsp.ready;
	assign stall    = finish && !out_free;
	assign rd_en    = (state_q == S_SCAN) && issue_on_q && !stall;
	assign wr_en    = finish && out_free && hit && (op_q == OP_RECORD);

	att_store #(
		.ENTRIES (ENTRIES)
	) u_store (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_idx  (idx_s1),
		.wr_data (addr_q),
		.rd_en   (rd_en),
		.rd_idx  (issue_idx_q),
		.rd_data (rd_data)
	);

	// Request latch and scan sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			issue_on_q  <= 1'b0;
			issue_idx_q <= '0;
			valid_s1    <= 1'b0;
			idx_s1      <= '0;
			used_q      <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					valid_s1 <= 1'b0;
					if (accept) begin
						state_q     <= S_SCAN;
						issue_idx_q <= '0;
						issue_on_q  <= 1'b1;
					end
				end
				S_SCAN: begin
					if (finish && out_free) begin
						// commit: update bitmap, drop any read in flight
						state_q    <= S_IDLE;
						issue_on_q <= 1'b0;
						valid_s1   <= 1'b0;
						if (hit) begin
							used_q[idx_s1] <= (op_q == OP_RECORD);
						end
					end else if (!stall) begin
						// advance: next slot into the compare stage
						valid_s1 <= rd_en;
						idx_s1   <= issue_idx_q;
						if (rd_en) begin
							issue_idx_q <= issue_idx_q + 1'b1;
							if (issue_idx_q == LAST) begin
								issue_on_q <= 1'b0;
							end
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Request payload, held for the whole scan.
	always_ff @(posedge clk) begin
		if (accept) begin
			op_q   <= att_op_t'(req.op);
			addr_q <= req.address;
		end
	end

	// Output register: load on commit, release on transfer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (finish && out_free) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (finish && out_free) begin
			out_slot_q <= hit ? SLOT_W'(idx_s1) : '0;
			case (op_q)
				OP_RECORD: out_status_q <= hit ? ST_RECORDED : ST_FULL;
				OP_CHECK:  out_status_q <= hit ? ST_FOUND : ST_NOT_FOUND;
				default:   out_status_q <= ST_NOT_FOUND;
			endcase
		end
	end

	`ASSERT_SAME(a_s1_in_scan, valid_s1, state_q == S_SCAN, "compare stage busy outside scan")
	`ASSERT_NEXT(a_commit_out, finish && out_free, out_valid_q, "commit did not load result")
	`ASSERT_NEXT(a_stall_hold, stall, valid_s1 && $stable(idx_s1), "stall lost compare stage")
	`ASSERT_NEXT(a_accept_clean, accept, state_q == S_SCAN && !valid_s1, "scan started dirty")

endmodule

`default_nettype wire
